>>> rtl/ffha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, status codes and control structs of the heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int POOL_BYTES_DEF = 4096;
  localparam int SizeW = 15;   // block size field of a header
  localparam int OffW  = 12;   // pointer and offset width at the ports
  localparam int ReqW  = 12;
  localparam int SumW  = 17;   // header position plus header plus size
  localparam int CntW  = 32;
  localparam int StW   = 3;

  localparam logic [StW-1:0] ST_ALLOC_OK = 3'd0;
  localparam logic [StW-1:0] ST_NO_FIT   = 3'd1;
  localparam logic [StW-1:0] ST_FREE_OK  = 3'd2;
  localparam logic [StW-1:0] ST_NULL     = 3'd3;
  localparam logic [StW-1:0] ST_UNKNOWN  = 3'd4;
  localparam logic [StW-1:0] ST_REPEAT   = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic           init;       // write the reset header at offset 0
    logic           load;       // take a new item, restart the walk
    logic           rd_at;      // read the header at the walk position
    logic           rd_next;    // read the header after the found block
    logic           adv;        // step the walk to the next block
    logic           keep_blk;   // hold the found block's size
    logic           merge_next; // absorb the free successor
    logic           wr_alloc;
    logic           wr_rest;
    logic           wr_blk;
    logic           wr_prev;
    logic           finish;
    logic [StW-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic alloc_room;  // header plus at least one byte fits before the end (alloc walk)
    logic free_room;   // a full header fits before the end (free walk)
    logic at_match;    // walk position is the freed block
    logic used;        // allocated flag of the header just read
    logic fits;        // header just read is free and large enough
    logic next_ok;     // successor header lies inside the pool
    logic rest_split;  // remainder big enough for its own header
    logic prev_merge;  // predecessor exists and is free
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/ffha_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer of the allocator: header walk, split, free and merge steps.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic           opcode,
  input  wire logic           pointer_null,
  input  wire ffha_pkg::stat_t stat,
  output ffha_pkg::cmd_t      cmd,
  output logic                busy
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EV   = 4'd3;
  localparam logic [3:0] S_RN   = 4'd4;
  localparam logic [3:0] S_EN   = 4'd5;
  localparam logic [3:0] S_WB   = 4'd6;
  localparam logic [3:0] S_WP   = 4'd7;
  localparam logic [3:0] S_WA   = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;

  logic [3:0] state, state_next;
  logic       op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      op    <= ffha_pkg::OP_ALLOC;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    op_next    = op;
    unique case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          op_next  = opcode;
          if (opcode == ffha_pkg::OP_FREE && pointer_null) begin
            cmd.finish = 1'b1;
            cmd.status = ffha_pkg::ST_NULL;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        if (op == ffha_pkg::OP_FREE ? stat.free_room : stat.alloc_room) begin
          cmd.rd_at  = 1'b1;
          state_next = S_EV;
        end else begin
          cmd.finish = 1'b1;
          cmd.status = (op == ffha_pkg::OP_FREE) ? ffha_pkg::ST_UNKNOWN
                                                 : ffha_pkg::ST_NO_FIT;
          state_next = S_IDLE;
        end
      end
      S_EV: begin
        if (op == ffha_pkg::OP_ALLOC) begin
          if (stat.fits) begin
            cmd.keep_blk = 1'b1;
            state_next   = S_WA;
          end else begin
            cmd.adv    = 1'b1;
            state_next = S_RD;
          end
        end else if (stat.at_match) begin
          if (!stat.used) begin
            cmd.finish = 1'b1;
            cmd.status = ffha_pkg::ST_REPEAT;
            state_next = S_IDLE;
          end else begin
            cmd.keep_blk = 1'b1;
            state_next   = S_RN;
          end
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_RD;
        end
      end
      S_RN: begin
        if (stat.next_ok) begin
          cmd.rd_next = 1'b1;
          state_next  = S_EN;
        end else begin
          state_next = S_WB;
        end
      end
      S_EN: begin
        cmd.merge_next = !stat.used;
        state_next     = S_WB;
      end
      S_WB: begin
        cmd.wr_blk = 1'b1;
        if (stat.prev_merge) begin
          state_next = S_WP;
        end else begin
          cmd.finish = 1'b1;
          cmd.status = ffha_pkg::ST_FREE_OK;
          state_next = S_IDLE;
        end
      end
      S_WP: begin
        cmd.wr_prev = 1'b1;
        cmd.finish  = 1'b1;
        cmd.status  = ffha_pkg::ST_FREE_OK;
        state_next  = S_IDLE;
      end
      S_WA: begin
        cmd.wr_alloc = 1'b1;
        if (stat.rest_split) begin
          state_next = S_WR;
        end else begin
          cmd.finish = 1'b1;
          cmd.status = ffha_pkg::ST_ALLOC_OK;
          state_next = S_IDLE;
        end
      end
      S_WR: begin
        cmd.wr_rest = 1'b1;
        cmd.finish  = 1'b1;
        cmd.status  = ffha_pkg::ST_ALLOC_OK;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ffha_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_dp
// Header store (two byte banks split by address parity), walk registers,
// size arithmetic, result registers and event counters.
// ----------------------------------------------------------------------------
module ffha_dp #(
  parameter int POOL_BYTES = ffha_pkg::POOL_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ffha_pkg::cmd_t              cmd,
  input  wire logic [ffha_pkg::ReqW-1:0]   request_size,
  input  wire logic [ffha_pkg::OffW-1:0]   free_offset,
  output ffha_pkg::stat_t                  stat,
  output logic                             done,
  output logic [ffha_pkg::StW-1:0]         status,
  output logic [ffha_pkg::OffW-1:0]        block_offset,
  output logic [ffha_pkg::CntW-1:0]        good_alloc_count,
  output logic [ffha_pkg::CntW-1:0]        failed_alloc_count,
  output logic [ffha_pkg::CntW-1:0]        good_free_count,
  output logic [ffha_pkg::CntW-1:0]        null_free_count,
  output logic [ffha_pkg::CntW-1:0]        unknown_free_count,
  output logic [ffha_pkg::CntW-1:0]        repeat_free_count
);

  localparam int AW    = $clog2(POOL_BYTES);
  localparam int BankD = (POOL_BYTES + 1) / 2;
  localparam int IW    = $clog2(BankD);
  localparam int SW    = ffha_pkg::SizeW;
  localparam int XW    = ffha_pkg::SumW;
  localparam logic [XW-1:0] PoolX = XW'(POOL_BYTES);

  logic [7:0] even_mem [BankD];
  logic [7:0] odd_mem  [BankD];
  logic [7:0] even_q, odd_q;
  logic       rd_par;

  logic [AW:0]   at, prev_at, next_at;
  logic [SW-1:0] prev_size, blk_size;
  logic          prev_valid, prev_used;
  logic [ffha_pkg::ReqW-1:0] req;
  logic [ffha_pkg::OffW-1:0] off;

  // header just read
  logic [7:0]    b0, b1;
  logic          h_used;
  logic [SW-1:0] h_size;

  assign b0     = rd_par ? odd_q : even_q;
  assign b1     = rd_par ? even_q : odd_q;
  assign h_used = b0[7];
  assign h_size = {b0[6:0], b1};

  logic [XW-1:0] at_x, at_step;
  assign at_x    = XW'(at);
  assign at_step = at_x + XW'(2) + XW'(h_size);

  // allocation split
  logic [SW-1:0] have_m_req, alloc_sz, rest;
  assign have_m_req = blk_size - SW'(req);
  assign alloc_sz   = (have_m_req == SW'(1)) ? blk_size : SW'(req);
  assign rest       = blk_size - alloc_sz;

  always_comb begin
    stat.alloc_room = (at_x + XW'(2)) < PoolX;
    stat.free_room  = (at_x + XW'(2)) <= PoolX;
    stat.at_match   = (at_x + XW'(2)) == XW'(off);
    stat.used       = h_used;
    stat.fits       = !h_used && (h_size >= SW'(req));
    stat.next_ok    = (XW'(next_at) + XW'(2)) <= PoolX;
    stat.rest_split = rest >= SW'(2);
    stat.prev_merge = prev_valid && !prev_used;
  end

  // read port
  logic [AW:0] rd_addr;
  logic        rd_en;
  logic [IW-1:0] rd_ie, rd_io;
  assign rd_addr = cmd.rd_next ? next_at : at;
  assign rd_en   = cmd.rd_at | cmd.rd_next;
  assign rd_io   = IW'(rd_addr >> 1);
  assign rd_ie   = rd_addr[0] ? IW'((rd_addr >> 1) + (AW+1)'(1)) : rd_io;

  // write port: one header (two bytes) per cycle
  logic [AW:0]   wr_addr;
  logic [SW-1:0] wr_size;
  logic          wr_flag, wr_en;
  logic [IW-1:0] wr_ie, wr_io;
  logic [7:0]    wb0, wb1;

  always_comb begin
    wr_en   = cmd.init | cmd.wr_alloc | cmd.wr_rest | cmd.wr_blk | cmd.wr_prev;
    wr_addr = at;
    wr_size = blk_size;
    wr_flag = 1'b0;
    if (cmd.init) begin
      wr_addr = '0;
      wr_size = SW'(POOL_BYTES - 2);
    end else if (cmd.wr_alloc) begin
      wr_size = alloc_sz;
      wr_flag = 1'b1;
    end else if (cmd.wr_rest) begin
      wr_addr = (AW+1)'(at_x + XW'(2) + XW'(alloc_sz));
      wr_size = rest - SW'(2);
    end else if (cmd.wr_prev) begin
      wr_addr = prev_at;
      wr_size = prev_size + blk_size + SW'(2);
    end
  end

  assign wb0   = {wr_flag, wr_size[SW-1:8]};
  assign wb1   = wr_size[7:0];
  assign wr_io = IW'(wr_addr >> 1);
  assign wr_ie = wr_addr[0] ? IW'((wr_addr >> 1) + (AW+1)'(1)) : wr_io;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      even_mem[wr_ie] <= wr_addr[0] ? wb1 : wb0;
      odd_mem[wr_io]  <= wr_addr[0] ? wb0 : wb1;
    end
    if (rd_en) begin
      even_q <= even_mem[rd_ie];
      odd_q  <= odd_mem[rd_io];
      rd_par <= rd_addr[0];
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      at         <= '0;
      prev_valid <= 1'b0;
      req        <= request_size;
      off        <= free_offset;
    end
    if (cmd.adv) begin
      prev_at    <= at;
      prev_size  <= h_size;
      prev_used  <= h_used;
      prev_valid <= 1'b1;
      at         <= (AW+1)'(at_step);
    end
    if (cmd.keep_blk) begin
      blk_size <= h_size;
      next_at  <= (AW+1)'(at_step);
    end
    if (cmd.merge_next) begin
      blk_size <= blk_size + h_size + SW'(2);
    end
  end

  // results and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      done               <= 1'b0;
      good_alloc_count   <= '0;
      failed_alloc_count <= '0;
      good_free_count    <= '0;
      null_free_count    <= '0;
      unknown_free_count <= '0;
      repeat_free_count  <= '0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        case (cmd.status)
          ffha_pkg::ST_ALLOC_OK: good_alloc_count   <= good_alloc_count + 1'b1;
          ffha_pkg::ST_NO_FIT:   failed_alloc_count <= failed_alloc_count + 1'b1;
          ffha_pkg::ST_FREE_OK:  good_free_count    <= good_free_count + 1'b1;
          ffha_pkg::ST_NULL:     null_free_count    <= null_free_count + 1'b1;
          ffha_pkg::ST_UNKNOWN:  unknown_free_count <= unknown_free_count + 1'b1;
          ffha_pkg::ST_REPEAT:   repeat_free_count  <= repeat_free_count + 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status       <= cmd.status;
      block_offset <= (cmd.status == ffha_pkg::ST_ALLOC_OK)
                      ? ffha_pkg::OffW'(at_x + XW'(2)) : '0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/first_fit_heap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit pool allocator with block split and neighbor coalescing.
// ----------------------------------------------------------------------------
// Sequence: a null free finishes from idle; otherwise each header on the walk
// is read, then evaluated, and the final header reads and writes follow.
// The done strobe rises in the cycle after the last step; start is taken
// again as soon as busy drops. Rate is set by the single header read port.
// Reset: one free block spans the pool (init write), counters zero.
module first_fit_heap_allocator #(
  parameter int POOL_BYTES = ffha_pkg::POOL_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      opcode,
  input  wire logic [ffha_pkg::ReqW-1:0] request_size,
  input  wire logic                      pointer_null,
  input  wire logic [ffha_pkg::OffW-1:0] free_offset,
  output logic                           done,
  output logic [ffha_pkg::StW-1:0]       status,
  output logic [ffha_pkg::OffW-1:0]      block_offset,
  output logic [ffha_pkg::CntW-1:0]      good_alloc_count,
  output logic [ffha_pkg::CntW-1:0]      failed_alloc_count,
  output logic [ffha_pkg::CntW-1:0]      good_free_count,
  output logic [ffha_pkg::CntW-1:0]      null_free_count,
  output logic [ffha_pkg::CntW-1:0]      unknown_free_count,
  output logic [ffha_pkg::CntW-1:0]      repeat_free_count
);

  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t stat;

  ffha_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .opcode       (opcode),
    .pointer_null (pointer_null),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  ffha_dp #(
    .POOL_BYTES (POOL_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .request_size       (request_size),
    .free_offset        (free_offset),
    .stat               (stat),
    .done               (done),
    .status             (status),
    .block_offset       (block_offset),
    .good_alloc_count   (good_alloc_count),
    .failed_alloc_count (failed_alloc_count),
    .good_free_count    (good_free_count),
    .null_free_count    (null_free_count),
    .unknown_free_count (unknown_free_count),
    .repeat_free_count  (repeat_free_count)
  );

endmodule
`default_nettype wire
